>>> rtl/core/transaction_journal_table_assert.svh
// assertion macros for the transaction journal table
// no dependencies; taken in by the rtl files that carry checks
`ifndef TRANSACTION_JOURNAL_TABLE_ASSERT_SVH
`define TRANSACTION_JOURNAL_TABLE_ASSERT_SVH

// same-cycle implication, checks off while reset is high
`define TJT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checks off while reset is high
`define TJT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/tjt_pkg.sv
// shared types and constants of the transaction journal table
// no dependencies; used by tjt_slot_table and transaction_journal_table
package tjt_pkg;

   localparam int ID_W       = 32;
   localparam int CMD_W      = 2;
   localparam int CNT_OUT_W  = 5;
   localparam int REQ_DATA_W = 128;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + 3 * ID_W + 2 * CNT_OUT_W);

   // command codes
   localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOG    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_ABORT  = 2'd3;

   // request from the command sequencer to the slot table
   typedef struct packed {
      logic            start;
      logic            op_log;
      logic [ID_W-1:0] txn_id;
      logic [ID_W-1:0] inode;
      logic [ID_W-1:0] block_no;
      logic [ID_W-1:0] length;
   } tjt_scan_req_type;

endpackage

>>> rtl/core/tjt_slot_table.sv
// slot storage of the journal: valid bits, id and payload memories, one compare unit
// a small sequencer walks the slots one per cycle; depends on tjt_pkg
module tjt_slot_table #(
   parameter int ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tjt_pkg::tjt_scan_req_type scan_req,
   output logic                      scan_done,
   output logic [$clog2(ENTRIES+1)-1:0] scan_removed
);
   import tjt_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_LOG   = 3'd1;
   localparam logic [2:0] T_MATCH = 3'd2;
   localparam logic [2:0] T_DRAIN = 3'd3;
   localparam logic [2:0] T_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]      cmp_idx_ff;
   logic [ID_W-1:0]    txn_rd_ff;
   logic [CW-1:0]      removed_ff, removed_in;
   logic               log_wr;
   logic               hit;

   logic [ID_W-1:0]     txn_mem [ENTRIES];
   logic [3*ID_W-1:0]   payload_mem [ENTRIES];

   // shared compare unit, one slot per cycle
   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (txn_rd_ff == scan_req.txn_id);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff;
      removed_in = removed_ff;
      cmp_vld_in = 1'b0;
      log_wr     = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (scan_req.start) begin
               idx_in     = '0;
               removed_in = '0;
               state_in   = scan_req.op_log ? T_LOG : T_MATCH;
            end
         end
         T_LOG: begin
            // first free slot takes the entry
            if (!valid_ff[idx_ff]) begin
               log_wr           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               state_in         = T_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         T_MATCH: begin
            cmp_vld_in = 1'b1;
            idx_in     = idx_ff + 1'b1;
            if (idx_ff == IW'(ENTRIES - 1)) begin
               state_in = T_DRAIN;
            end
         end
         T_DRAIN: begin
            state_in = T_DONE;
         end
         T_DONE: begin
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      // drop a matching slot
      if (hit) begin
         valid_in[cmp_idx_ff] = 1'b0;
         removed_in           = removed_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= T_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // scan index, compare stage and tally
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= idx_ff;
      removed_ff <= removed_in;
   end

   // memories, registered read of the id
   always_ff @(posedge clock) begin
      if (log_wr) begin
         txn_mem[idx_ff]     <= scan_req.txn_id;
         payload_mem[idx_ff] <= {scan_req.length, scan_req.block_no, scan_req.inode};
      end
      txn_rd_ff <= txn_mem[idx_ff];
   end

   assign scan_done    = (state_ff == T_DONE);
   assign scan_removed = removed_ff;

endmodule

>>> rtl/core/transaction_journal_table.sv
// begin and rejected commands go straight to the response stage; log, commit and abort
// first wait for the slot scan, which walks the slots one per cycle
// one request at a time; the next is taken once the previous response is registered,
// also while that response still waits
// reset: synchronous, active high; clears all valid marks, ids restart at 1, totals at 0
// journal table top; uses tjt_pkg, tjt_slot_table and transaction_journal_table_assert.svh
`include "transaction_journal_table_assert.svh"

module transaction_journal_table #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // txn_id[31:0], inode[63:32], block_no[95:64], length[127:96]
   input  logic [tjt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0], zero above
   input  logic [tjt_pkg::REQ_USER_W-1:0]   req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[0], new_txn_id[32:1], removed_count[37:33], entries_in_use[42:38],
   // commit_total[74:43], abort_total[106:75], zero above
   output logic [tjt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tjt_pkg::*;

   localparam int CW = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BUSY = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [ID_W-1:0]       id_ff, inode_ff, block_ff, length_ff;
   logic                  err_ff, err_in;
   logic                  start_ff, start_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in, next_id_inc;
   logic [CW-1:0]         used_ff, used_in;
   logic [CW-1:0]         removed_ff, removed_in;
   logic [ID_W-1:0]       commit_ff, commit_in;
   logic [ID_W-1:0]       abort_ff, abort_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  accept, fin_go, id_zero, req_id_zero, full;
   logic                  status;
   logic [ID_W-1:0]       issued;
   logic                  scan_done;
   logic [CW-1:0]         scan_removed;
   tjt_scan_req_type      scan_req;

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == S_IDLE);
   assign req_id_zero = (req_tdata[ID_W-1:0] == '0);
   assign full        = (used_ff == CW'(ENTRIES));
   assign id_zero     = (id_ff == '0);
   assign fin_go      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign next_id_inc = next_id_ff + 1'b1;

   // slot table
   assign scan_req.start    = start_ff;
   assign scan_req.op_log   = (cmd_ff == CMD_LOG);
   assign scan_req.txn_id   = id_ff;
   assign scan_req.inode    = inode_ff;
   assign scan_req.block_no = block_ff;
   assign scan_req.length   = length_ff;

   tjt_slot_table #(
      .ENTRIES (ENTRIES)
   ) u_slots (
      .clock        (clock),
      .reset        (reset),
      .scan_req     (scan_req),
      .scan_done    (scan_done),
      .scan_removed (scan_removed)
   );

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      err_in     = err_ff;
      start_in   = 1'b0;
      removed_in = removed_ff;
      used_in    = used_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               removed_in = '0;
               err_in     = 1'b0;
               state_in   = S_FIN;
               case (req_tuser[CMD_W-1:0])
                  CMD_LOG: begin
                     if (req_id_zero || full) begin
                        err_in = 1'b1;
                     end else begin
                        start_in = 1'b1;
                        state_in = S_BUSY;
                     end
                  end
                  CMD_COMMIT, CMD_ABORT: begin
                     if (!req_id_zero) begin
                        start_in = 1'b1;
                        state_in = S_BUSY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BUSY: begin
            if (scan_done) begin
               state_in = S_FIN;
               if (cmd_ff == CMD_LOG) begin
                  used_in = used_ff + 1'b1;
               end else begin
                  removed_in = scan_removed;
                  used_in    = used_ff - scan_removed;
               end
            end
         end
         S_FIN: begin
            if (fin_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response fields and counter updates
   always_comb begin
      next_id_in = next_id_ff;
      commit_in  = commit_ff;
      abort_in   = abort_ff;
      issued     = '0;
      status     = 1'b0;
      case (cmd_ff)
         CMD_BEGIN: begin
            issued = next_id_ff;
            if (fin_go) begin
               // ids skip zero on wrap
               next_id_in = (next_id_inc == '0) ? ID_W'(1) : next_id_inc;
            end
         end
         CMD_LOG: begin
            status = err_ff;
         end
         CMD_COMMIT: begin
            status = id_zero || (removed_ff == '0);
            if (fin_go && !id_zero) begin
               commit_in = commit_ff + 1'b1;
            end
         end
         default: begin
            status = id_zero;
            if (fin_go && !id_zero) begin
               abort_in = abort_ff + 1'b1;
            end
         end
      endcase
      rsp_data_in = {{RSP_PAD_W{1'b0}}, abort_in, commit_in, CNT_OUT_W'(used_ff),
                     CNT_OUT_W'(removed_ff), issued, status};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         next_id_ff   <= ID_W'(1);
         used_ff      <= '0;
         commit_ff    <= '0;
         abort_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         next_id_ff   <= next_id_in;
         used_ff      <= used_in;
         commit_ff    <= commit_in;
         abort_ff     <= abort_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload and response register
   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      removed_ff <= removed_in;
      if (accept) begin
         cmd_ff    <= req_tuser[CMD_W-1:0];
         id_ff     <= req_tdata[ID_W-1:0];
         inode_ff  <= req_tdata[2*ID_W-1:ID_W];
         block_ff  <= req_tdata[3*ID_W-1:2*ID_W];
         length_ff <= req_tdata[4*ID_W-1:3*ID_W];
      end
      if (fin_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `TJT_ASSERT_IMP(a_used_bound, 1'b1, used_ff <= CW'(ENTRIES), "slot count above table size")
   `TJT_ASSERT_IMP(a_done_busy, scan_done, state_ff == S_BUSY, "slot scan ended while not busy")
   `TJT_ASSERT_IMP(a_id_nonzero, 1'b1, next_id_ff != '0, "next transaction id is zero")
   `TJT_ASSERT_NXT(a_log_count, scan_done && (cmd_ff == CMD_LOG),
      used_ff == CW'($past(used_ff) + 1'b1), "log did not add one slot")

endmodule
